@@ src/trackball_pulse_accumulator_macros.svh @@
// Assertion macros for the trackball pulse accumulator.
// Expects clk and arst_n in scope where the macros are used.
`ifndef TRACKBALL_PULSE_ACCUMULATOR_MACROS_SVH
`define TRACKBALL_PULSE_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TPA_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpa assertion failed");

// Next-cycle implication, disabled during reset
`define TPA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpa assertion failed");

`endif

@@ src/tpa_pkg.sv @@
// Shared types and constants for the trackball pulse accumulator.
// No dependencies; used by the core, result queue and top level.
package tpa_pkg;

	// Input item action codes
	typedef enum logic [1:0] {
		ACT_TICK   = 2'd0,
		ACT_PULSE  = 2'd1,
		ACT_BUTTON = 2'd2
	} action_t;

	// Result axis codes
	typedef enum logic [1:0] {
		AXIS_X      = 2'd0,
		AXIS_Y      = 2'd1,
		AXIS_BUTTON = 2'd2
	} axis_t;

	// Configuration register indexes
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INTERVAL = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT_X = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_INVERT_Y = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SWAP_XY  = 2'd3;
	localparam logic [CFG_DATA_BITS-1:0]  INTERVAL_RESET = 16'd8;

	// Result amount range
	localparam int AMOUNT_BITS = 9;
	localparam logic signed [AMOUNT_BITS-1:0] AMOUNT_MAX = 9'sd255;

	// Result queue geometry
	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_BITS = 2;
	localparam int Q_CNT_BITS = 3;

	typedef struct packed {
		logic [1:0]                    action;
		logic [1:0]                    direction;
		logic                          button_level;
	} item_t;

	typedef struct packed {
		logic                          wr;
		logic [CFG_INDEX_BITS-1:0]     index;
		logic [CFG_DATA_BITS-1:0]      data;
	} cfg_wr_t;

	typedef struct packed {
		logic [1:0]                    axis;
		logic signed [AMOUNT_BITS-1:0] amount;
		logic                          sync;
	} result_t;

	// Up to two results handed to the queue in one cycle
	typedef struct packed {
		logic [1:0]                    n;
		result_t                       res0;
		result_t                       res1;
	} push_t;

endpackage

@@ src/tpa_item_if.sv @@
// Input item channel of the trackball pulse accumulator.
// Stand-alone interface, no dependencies.
interface tpa_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] direction;
	logic       button_level;

	modport source (output valid, action, direction, button_level, input ready);
	modport sink (input valid, action, direction, button_level, output ready);
endinterface

@@ src/tpa_result_if.sv @@
// Result item channel of the trackball pulse accumulator.
// Stand-alone interface, no dependencies.
interface tpa_result_if;
	logic              valid;
	logic              ready;
	logic [1:0]        axis;
	logic signed [8:0] amount;
	logic              sync;

	modport source (output valid, axis, amount, sync, input ready);
	modport sink (input valid, axis, amount, sync, output ready);
endinterface

@@ src/tpa_cfg_if.sv @@
// Configuration write channel of the trackball pulse accumulator.
// Stand-alone interface, no dependencies.
interface tpa_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ src/tpa_core.sv @@
// Input register, pulse counters, report timer and result forming.
// Depends on tpa_pkg.
module tpa_core #(
	parameter int COUNT_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  tpa_pkg::item_t  item,
	input  tpa_pkg::cfg_wr_t cfg_wr,
	output tpa_pkg::push_t  push
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	// Delta width: room for the difference and the clamp limit
	localparam int DW = (COUNT_BITS + 1 > 10) ? COUNT_BITS + 1 : 10;
	localparam logic signed [DW-1:0] LIM = DW'(255);

	logic                          valid_s1;
	tpa_pkg::item_t                item_s1;

	logic [COUNT_BITS-1:0]         cnt_q [4];
	logic                          pending_q;
	logic [15:0]                   ticks_q;

	logic [15:0]                   interval_q;
	logic                          invert_x_q;
	logic                          invert_y_q;
	logic                          swap_xy_q;

	logic                          is_pulse;
	logic                          is_tick;
	logic                          is_button;
	logic                          expire;
	logic signed [DW-1:0]          dx, dy, sx, sy, ix, iy;
	logic signed [tpa_pkg::AMOUNT_BITS-1:0] xc, yc;
	logic                          xnz, ynz;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= tpa_pkg::INTERVAL_RESET;
			invert_x_q <= 1'b0;
			invert_y_q <= 1'b0;
			swap_xy_q  <= 1'b0;
		end else if (cfg_wr.wr) begin
			case (cfg_wr.index)
				tpa_pkg::REG_INTERVAL: interval_q <= cfg_wr.data;
				tpa_pkg::REG_INVERT_X: invert_x_q <= cfg_wr.data[0];
				tpa_pkg::REG_INVERT_Y: invert_y_q <= cfg_wr.data[0];
				tpa_pkg::REG_SWAP_XY:  swap_xy_q  <= cfg_wr.data[0];
				default: ;
			endcase
		end
	end

	// Decode of the registered item
	assign is_pulse  = valid_s1 && (item_s1.action == tpa_pkg::ACT_PULSE);
	assign is_tick   = valid_s1 && (item_s1.action == tpa_pkg::ACT_TICK);
	assign is_button = valid_s1 && (item_s1.action == tpa_pkg::ACT_BUTTON);
	assign expire    = is_tick && pending_q && (ticks_q <= 16'd1);

	// Counters and one-shot timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
			pending_q <= 1'b0;
			ticks_q   <= '0;
		end else if (is_pulse) begin
			if (cnt_q[item_s1.direction] != CNT_MAX) begin
				cnt_q[item_s1.direction] <= cnt_q[item_s1.direction] + 1'b1;
			end
			if (!pending_q) begin
				pending_q <= 1'b1;
				ticks_q   <= interval_q;
			end
		end else if (expire) begin
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
			pending_q <= 1'b0;
			ticks_q   <= '0;
		end else if (is_tick && pending_q) begin
			ticks_q <= ticks_q - 16'd1;
		end
	end

	// Deltas: right - left, down - up; swap, then invert, then clamp
	always_comb begin
		dx = $signed({{(DW-COUNT_BITS){1'b0}}, cnt_q[3]})
			- $signed({{(DW-COUNT_BITS){1'b0}}, cnt_q[2]});
		dy = $signed({{(DW-COUNT_BITS){1'b0}}, cnt_q[1]})
			- $signed({{(DW-COUNT_BITS){1'b0}}, cnt_q[0]});
		sx = swap_xy_q ? dy : dx;
		sy = swap_xy_q ? dx : dy;
		ix = invert_x_q ? -sx : sx;
		iy = invert_y_q ? -sy : sy;
		if (ix > LIM) begin
			xc = tpa_pkg::AMOUNT_MAX;
		end else if (ix < -LIM) begin
			xc = -tpa_pkg::AMOUNT_MAX;
		end else begin
			xc = ix[tpa_pkg::AMOUNT_BITS-1:0];
		end
		if (iy > LIM) begin
			yc = tpa_pkg::AMOUNT_MAX;
		end else if (iy < -LIM) begin
			yc = -tpa_pkg::AMOUNT_MAX;
		end else begin
			yc = iy[tpa_pkg::AMOUNT_BITS-1:0];
		end
		xnz = (xc != '0);
		ynz = (yc != '0);
	end

	// Results for the queue
	always_comb begin
		push.n           = 2'd0;
		push.res0.axis   = tpa_pkg::AXIS_Y;
		push.res0.amount = yc;
		push.res0.sync   = 1'b1;
		push.res1.axis   = tpa_pkg::AXIS_Y;
		push.res1.amount = yc;
		push.res1.sync   = 1'b1;
		if (is_button) begin
			push.n           = 2'd1;
			push.res0.axis   = tpa_pkg::AXIS_BUTTON;
			push.res0.amount = {{(tpa_pkg::AMOUNT_BITS-1){1'b0}}, item_s1.button_level};
		end else if (expire) begin
			push.n = {1'b0, xnz} + {1'b0, ynz};
			if (xnz) begin
				push.res0.axis   = tpa_pkg::AXIS_X;
				push.res0.amount = xc;
				push.res0.sync   = !ynz;
			end
		end
	end

endmodule

@@ src/tpa_out_queue.sv @@
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on tpa_pkg and tpa_result_if.
module tpa_out_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tpa_pkg::push_t                    push,
	output logic [tpa_pkg::Q_CNT_BITS-1:0]    count,
	tpa_result_if.source                      results
);

	tpa_pkg::result_t                 mem_q [tpa_pkg::Q_DEPTH];
	logic [tpa_pkg::Q_PTR_BITS-1:0]   wr_ptr_q;
	logic [tpa_pkg::Q_PTR_BITS-1:0]   rd_ptr_q;
	logic [tpa_pkg::Q_CNT_BITS-1:0]   count_q;
	logic                             pop;
	logic [tpa_pkg::Q_PTR_BITS-1:0]   wr_ptr_nx;

	assign pop       = results.valid && results.ready;
	assign wr_ptr_nx = wr_ptr_q + 1'b1;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.n;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + {1'b0, push.n} - {{(tpa_pkg::Q_CNT_BITS-1){1'b0}}, pop};
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.res0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_nx] <= push.res1;
		end
	end

	assign count          = count_q;
	assign results.valid  = (count_q != '0);
	assign results.axis   = mem_q[rd_ptr_q].axis;
	assign results.amount = mem_q[rd_ptr_q].amount;
	assign results.sync   = mem_q[rd_ptr_q].sync;

endmodule

@@ src/trackball_pulse_accumulator.sv @@
// Trackball pulse accumulator: input register, counters and timer, result queue.
// Depends on tpa_pkg, the three channel interfaces, tpa_core, tpa_out_queue
// and trackball_pulse_accumulator_macros.svh.
//
// Channels: items carries ticks, direction pulse edges and button changes;
// results carries axis, amount and sync; cfg writes the four registers
// (interval, invert x, invert y, swap) and is always ready.
// An accepted item is registered, then processed in the next cycle; its
// results are then registered into a four-entry queue, and results.valid
// is up once they are stored. One item can be accepted every cycle while
// items.ready is high. A report expiry gives up to two results, which leave
// the queue one after the other as the receiver takes them.
// items.ready is low while the queue, plus what the registered item is
// about to add, leaves less than room for two more results; a stalled
// receiver therefore fills the queue and then holds off new items.
// Reset clears the counters, the timer, the queue and the registers to
// their defaults (interval 8, no swap, no inversion).
`include "trackball_pulse_accumulator_macros.svh"

module trackball_pulse_accumulator #(
	parameter int COUNT_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	tpa_item_if.sink     items,
	tpa_result_if.source results,
	tpa_cfg_if.sink      cfg
);

	tpa_pkg::item_t                   item;
	tpa_pkg::cfg_wr_t                 cfg_wr;
	tpa_pkg::push_t                   push;
	logic [tpa_pkg::Q_CNT_BITS-1:0]   q_count;
	logic                             take;

	// Flow control: keep room for the registered item and one more
	assign items.ready = ({1'b0, q_count} + {2'b00, push.n}) <= 4'd2;
	assign take        = items.valid && items.ready;
	assign cfg.ready   = 1'b1;

	assign item.action       = items.action;
	assign item.direction    = items.direction;
	assign item.button_level = items.button_level;
	assign cfg_wr.wr         = cfg.valid && cfg.ready;
	assign cfg_wr.index      = cfg.index;
	assign cfg_wr.data       = cfg.data;

	tpa_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.cfg_wr (cfg_wr),
		.push   (push)
	);

	tpa_out_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.count   (q_count),
		.results (results)
	);

	// Checks
	`TPA_ASSERT_IMPL(a_count_bound, 1'b1, q_count <= 3'd4)
	`TPA_ASSERT_IMPL(a_full_stalls, q_count == 3'd4, !items.ready)
	`TPA_ASSERT_NEXT(a_push_shows, push.n != 2'd0, results.valid)

endmodule
